// ===== hw/rtl/sdsf_pkg.sv =====
`default_nettype none
package sdsf_pkg;

  localparam int FB_W    = 24;
  localparam int GAIN_W  = 8;
  localparam int SIG_W   = 24;
  localparam int DISP_W  = 16;
  localparam int OUT_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_BASELINE    = 3'd0,
    CFG_STEREO_SIGMA_GAIN = 3'd1,
    CFG_SECOND_SIGMA_GAIN = 3'd2,
    CFG_SIGMA_CEILING     = 3'd3,
    CFG_SIGMA_FLOOR       = 3'd4
  } cfg_idx_t;

  localparam logic [FB_W-1:0]   FB_RST    = 24'd204800;
  localparam logic [GAIN_W-1:0] SSG_RST   = 8'd32;
  localparam logic [GAIN_W-1:0] S2G_RST   = 8'd64;
  localparam logic [SIG_W-1:0]  CEIL_RST  = 24'd6553600;
  localparam logic [SIG_W-1:0]  FLOOR_RST = 24'd655;

endpackage
`default_nettype wire

// ===== hw/rtl/sdsf_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per stage. Requires in_num / in_den < 2^Q_W.
module sdsf_div #(
  parameter int N_W    = 55,
  parameter int D_W    = 32,
  parameter int Q_W    = 54,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [N_W-1:0]    in_num,
  input  wire logic [D_W-1:0]    in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [Q_W-1:0]         out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  logic              vld_src  [Q_W];
  logic [D_W-1:0]    rem_src  [Q_W];
  logic [Q_W-1:0]    num_src  [Q_W];
  logic [Q_W-1:0]    quo_src  [Q_W];
  logic [D_W-1:0]    den_src  [Q_W];
  logic [SIDE_W-1:0] side_src [Q_W];

  logic              vld_q  [Q_W];
  logic [D_W-1:0]    rem_q  [Q_W];
  logic [Q_W-1:0]    num_q  [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [D_W-1:0]    den_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [D_W:0] r2;
    logic         take;

    if (i == 0) begin : g_first
      assign vld_src[i]  = in_valid;
      assign rem_src[i]  = D_W'(in_num[N_W-1:Q_W]);
      assign num_src[i]  = in_num[Q_W-1:0];
      assign quo_src[i]  = '0;
      assign den_src[i]  = in_den;
      assign side_src[i] = in_side;
    end else begin : g_next
      assign vld_src[i]  = vld_q[i-1];
      assign rem_src[i]  = rem_q[i-1];
      assign num_src[i]  = num_q[i-1];
      assign quo_src[i]  = quo_q[i-1];
      assign den_src[i]  = den_q[i-1];
      assign side_src[i] = side_q[i-1];
    end

    assign r2   = {rem_src[i], num_src[i][Q_W-1]};
    assign take = r2 >= {1'b0, den_src[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_src[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= take ? D_W'(r2 - {1'b0, den_src[i]}) : r2[D_W-1:0];
        num_q[i]  <= num_src[i] << 1;
        quo_q[i]  <= {quo_src[i][Q_W-2:0], take};
        den_q[i]  <= den_src[i];
        side_q[i] <= side_src[i];
      end
    end
  end

  assign out_valid = vld_q[Q_W-1];
  assign out_quo   = quo_q[Q_W-1];
  assign out_side  = side_q[Q_W-1];

endmodule
`default_nettype wire

// ===== hw/rtl/sdsf_isqrt.sv =====
`default_nettype none
// Integer square root, one result bit per stage. V_W is even, input below 2^V_W.
module sdsf_isqrt #(
  parameter int V_W    = 62,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [V_W-1:0]    in_val,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [V_W/2-1:0]       out_root,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int NSTG = V_W / 2;

  logic              vld_src  [NSTG];
  logic [V_W-1:0]    v_src    [NSTG];
  logic [V_W-1:0]    r_src    [NSTG];
  logic [SIDE_W-1:0] side_src [NSTG];

  logic              vld_q  [NSTG];
  logic [V_W-1:0]    v_q    [NSTG];
  logic [V_W-1:0]    r_q    [NSTG];
  logic [SIDE_W-1:0] side_q [NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    localparam int POS = V_W - 2 - 2 * i;
    localparam logic [V_W-1:0] BIT = {{(V_W-1){1'b0}}, 1'b1} << POS;
    logic [V_W-1:0] t;
    logic           fit;

    if (i == 0) begin : g_first
      assign vld_src[i]  = in_valid;
      assign v_src[i]    = in_val;
      assign r_src[i]    = '0;
      assign side_src[i] = in_side;
    end else begin : g_next
      assign vld_src[i]  = vld_q[i-1];
      assign v_src[i]    = v_q[i-1];
      assign r_src[i]    = r_q[i-1];
      assign side_src[i] = side_q[i-1];
    end

    assign t   = r_src[i] + BIT;
    assign fit = v_src[i] >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_src[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[i]    <= fit ? v_src[i] - t : v_src[i];
        r_q[i]    <= fit ? (r_src[i] >> 1) + BIT : r_src[i] >> 1;
        side_q[i] <= side_src[i];
      end
    end
  end

  assign out_valid = vld_q[NSTG-1];
  assign out_root  = r_q[NSTG-1][NSTG-1:0];
  assign out_side  = side_q[NSTG-1];

endmodule
`default_nettype wire

// ===== hw/rtl/sdsf_obuf.sv =====
`default_nettype none
// Two-entry output buffer; full is derived from registers only.
module sdsf_obuf #(
  parameter int W = 50
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   cnt;
  logic         pop;

  assign pop       = out_valid && out_ready;
  assign full      = cnt == 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/stereo_depth_sigma_fusion_core.sv =====
`default_nettype none
// Channel   Dir  Fields (low bit first)
// s_*       in   tdata: disparity, disparity_sigma, second_depth, second_sigma; tuser: second_valid
// m_*       out  tdata: out_depth, out_sigma; tuser: was_fused, sigma_replaced
// cfg_*     in   cfg_index selects register, cfg_data carries the value
//
// One pixel per cycle while the output buffer is not full. In order: two input stages, a
// 54-stage divider for stereo depth and sigma, five fusion stages, a 62-stage divider for
// weight and variance quotients, a 31-stage square root and the output buffer.
// rst clears valid bits and loads register defaults. When the two-entry output
// buffer is full the whole pipeline holds; nothing is dropped or repeated.
module stereo_depth_sigma_fusion_core #(
  parameter int DEPTH_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // disparity, disparity_sigma, second_depth, second_sigma
  input  wire logic        s_tuser,   // second_valid
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // out_depth, out_sigma
  output logic [1:0]       m_tuser,   // was_fused, sigma_replaced
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [sdsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sdsf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DB      = DEPTH_BITS;
  localparam int NUM1_W  = 55;
  localparam int Q1_W    = 54;
  localparam int D1_W    = 32;
  localparam int A_W     = 31;
  localparam int W_W     = 2 * A_W;
  localparam int SUM_W   = W_W + 1;
  localparam int NSIG_W  = 2 * W_W;
  localparam int NSTEP_W = DB + W_W;
  localparam int PH_W    = W_W - A_W;
  localparam logic [DB-1:0] DMAX = {DB{1'b1}};
  localparam int OB_W    = 2 * sdsf_pkg::OUT_W + 2;

  typedef struct packed {
    logic          d0;
    logic          fv;
    logic          rep;
    logic [DB-1:0] db;
    logic [DB-1:0] sb;
  } side1_t;

  typedef struct packed {
    logic [DB-1:0] da;
    logic [DB-1:0] db;
    logic [DB-1:0] sa;
    logic          ge;
    logic          sbz;
    logic          fv;
    logic          rep;
    logic          sh;
  } side2_t;

  typedef struct packed {
    side2_t        s;
    logic [DB-1:0] step;
  } side3_t;

  function automatic logic [DB-1:0] sat(input logic [63:0] v);
    sat = (v > 64'(DMAX)) ? DMAX : v[DB-1:0];
  endfunction

  // configuration registers
  logic [sdsf_pkg::FB_W-1:0]   fb;
  logic [sdsf_pkg::GAIN_W-1:0] ssg;
  logic [sdsf_pkg::GAIN_W-1:0] s2g;
  logic [sdsf_pkg::SIG_W-1:0]  ceil_r;
  logic [sdsf_pkg::SIG_W-1:0]  flr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fb     <= sdsf_pkg::FB_RST;
      ssg    <= sdsf_pkg::SSG_RST;
      s2g    <= sdsf_pkg::S2G_RST;
      ceil_r <= sdsf_pkg::CEIL_RST;
      flr    <= sdsf_pkg::FLOOR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sdsf_pkg::CFG_FOCAL_BASELINE:    fb     <= cfg_data;
        sdsf_pkg::CFG_STEREO_SIGMA_GAIN: ssg    <= cfg_data[sdsf_pkg::GAIN_W-1:0];
        sdsf_pkg::CFG_SECOND_SIGMA_GAIN: s2g    <= cfg_data[sdsf_pkg::GAIN_W-1:0];
        sdsf_pkg::CFG_SIGMA_CEILING:     ceil_r <= cfg_data;
        sdsf_pkg::CFG_SIGMA_FLOOR:       flr    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic ob_full;

  assign en       = !ob_full;
  assign s_tready = en;

  logic [sdsf_pkg::DISP_W-1:0] in_d;
  logic [sdsf_pkg::DISP_W-1:0] in_s;
  logic [sdsf_pkg::SIG_W-1:0]  in_db;
  logic [sdsf_pkg::SIG_W-1:0]  in_sraw;

  assign in_d    = s_tdata[15:0];
  assign in_s    = s_tdata[31:16];
  assign in_db   = s_tdata[55:32];
  assign in_sraw = s_tdata[79:56];

  // P1: first products
  logic          p1_v;
  logic [39:0]   p1_fbs;
  logic [31:0]   p1_dsq;
  logic [31:0]   p1_sbp;
  logic [15:0]   p1_d;
  logic          p1_fv;
  logic          p1_sinf;
  logic [DB-1:0] p1_db;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (en) begin
      p1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_fbs  <= 40'(fb) * 40'(in_s);
      p1_dsq  <= 32'(in_d) * 32'(in_d);
      p1_sbp  <= 32'(in_sraw) * 32'(s2g);
      p1_d    <= in_d;
      p1_fv   <= s_tuser;
      p1_sinf <= in_sraw == {sdsf_pkg::SIG_W{1'b1}};
      p1_db   <= sat(64'(in_db));
    end
  end

  // P2: numerators, second sigma
  logic              p2_v;
  logic [NUM1_W-1:0] p2_nsa;
  logic [NUM1_W-1:0] p2_nda;
  logic [D1_W-1:0]   p2_dsq;
  logic [D1_W-1:0]   p2_dd;
  side1_t            p2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (en) begin
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_nsa       <= (NUM1_W'(p1_fbs) * NUM1_W'(ssg)) << 6;
      p2_nda       <= NUM1_W'(fb) << 10;
      p2_dsq       <= p1_dsq;
      p2_dd        <= D1_W'(p1_d);
      p2_side.d0   <= p1_d == '0;
      p2_side.fv   <= p1_fv;
      p2_side.rep  <= (p1_d == '0) || (p1_fv && p1_sinf);
      p2_side.db   <= p1_db;
      p2_side.sb   <= p1_sinf ? sat(64'(ceil_r)) : sat(64'(p1_sbp >> 4));
    end
  end

  logic            dv1_v;
  logic [Q1_W-1:0] q_sa;
  logic [Q1_W-1:0] q_da;
  side1_t          dv1_side;

  sdsf_div #(.N_W(NUM1_W), .D_W(D1_W), .Q_W(Q1_W), .SIDE_W($bits(side1_t))) u_div_sa (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(p2_v), .in_num(p2_nsa), .in_den(p2_dsq), .in_side(p2_side),
    .out_valid(dv1_v), .out_quo(q_sa), .out_side(dv1_side)
  );

  sdsf_div #(.N_W(NUM1_W), .D_W(D1_W), .Q_W(Q1_W), .SIDE_W(1)) u_div_da (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(p2_v), .in_num(p2_nda), .in_den(p2_dd), .in_side(1'b0),
    .out_valid(), .out_quo(q_da), .out_side()
  );

  // F1: stereo depth and sigma, floor and saturate
  logic            [Q1_W-1:0] sa_raw;
  logic            [Q1_W-1:0] sa_flr;
  logic          f1_v;
  logic [DB-1:0] f1_da;
  logic [DB-1:0] f1_sa;
  logic [DB-1:0] f1_sb;
  logic [DB-1:0] f1_db;
  logic          f1_fv;
  logic          f1_rep;

  assign sa_raw = dv1_side.d0 ? Q1_W'(ceil_r) : q_sa;
  assign sa_flr = (sa_raw < Q1_W'(flr)) ? Q1_W'(flr) : sa_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (en) begin
      f1_v <= dv1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_da  <= dv1_side.d0 ? DMAX : sat(64'(q_da));
      f1_sa  <= sat(64'(sa_flr));
      f1_sb  <= dv1_side.sb;
      f1_db  <= dv1_side.db;
      f1_fv  <= dv1_side.fv;
      f1_rep <= dv1_side.rep;
    end
  end

  // F2: common shift so both sigmas fit 31 bits
  logic [DB-1:0]  m_sig;
  logic [32:0]    m_ext;
  logic           sh_c;
  logic           f2_v;
  logic [A_W-1:0] f2_a2;
  logic [A_W-1:0] f2_b2;
  logic           f2_sh;
  logic [DB-1:0]  f2_da;
  logic [DB-1:0]  f2_db;
  logic [DB-1:0]  f2_sa;
  logic           f2_sbz;
  logic           f2_fv;
  logic           f2_rep;

  assign m_sig = (f1_sa > f1_sb) ? f1_sa : f1_sb;
  assign m_ext = 33'(m_sig);
  assign sh_c  = m_ext[31];

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else if (en) begin
      f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_a2  <= A_W'(33'(f1_sa) >> sh_c);
      f2_b2  <= A_W'(33'(f1_sb) >> sh_c);
      f2_sh  <= sh_c;
      f2_da  <= f1_da;
      f2_db  <= f1_db;
      f2_sa  <= f1_sa;
      f2_sbz <= f1_sb == '0;
      f2_fv  <= f1_fv;
      f2_rep <= f1_rep;
    end
  end

  // F3: weights and their product root
  logic           f3_v;
  logic [W_W-1:0] f3_wa;
  logic [W_W-1:0] f3_wb;
  logic [W_W-1:0] f3_p;
  logic [DB-1:0]  f3_diff;
  side2_t         f3_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_v <= 1'b0;
    end else if (en) begin
      f3_v <= f2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_wa   <= W_W'(f2_b2) * W_W'(f2_b2);
      f3_wb   <= W_W'(f2_a2) * W_W'(f2_a2);
      f3_p    <= W_W'(f2_a2) * W_W'(f2_b2);
      f3_diff <= (f2_db >= f2_da) ? f2_db - f2_da : f2_da - f2_db;
      f3_s.da  <= f2_da;
      f3_s.db  <= f2_db;
      f3_s.sa  <= f2_sa;
      f3_s.ge  <= f2_db >= f2_da;
      f3_s.sbz <= f2_sbz;
      f3_s.fv  <= f2_fv;
      f3_s.rep <= f2_rep;
      f3_s.sh  <= f2_sh;
    end
  end

  // F4: sum and partial products
  logic               f4_v;
  logic [SUM_W-1:0]   f4_sum;
  logic [DB+PH_W-1:0] f4_dwh;
  logic [DB+A_W-1:0]  f4_dwl;
  logic [W_W-1:0]     f4_hh;
  logic [W_W-1:0]     f4_hl;
  logic [W_W-1:0]     f4_ll;
  side2_t             f4_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      f4_v <= 1'b0;
    end else if (en) begin
      f4_v <= f3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4_sum <= SUM_W'(f3_wa) + SUM_W'(f3_wb);
      f4_dwh <= (DB+PH_W)'(f3_diff) * (DB+PH_W)'(f3_wb[W_W-1:A_W]);
      f4_dwl <= (DB+A_W)'(f3_diff) * (DB+A_W)'(f3_wb[A_W-1:0]);
      f4_hh  <= W_W'(f3_p[W_W-1:A_W]) * W_W'(f3_p[W_W-1:A_W]);
      f4_hl  <= W_W'(f3_p[W_W-1:A_W]) * W_W'(f3_p[A_W-1:0]);
      f4_ll  <= W_W'(f3_p[A_W-1:0]) * W_W'(f3_p[A_W-1:0]);
      f4_s   <= f3_s;
    end
  end

  // F5: assemble wide numerators
  logic               f5_v;
  logic [SUM_W-1:0]   f5_sum;
  logic [NSTEP_W-1:0] f5_nstep;
  logic [NSIG_W-1:0]  f5_nsig;
  side2_t             f5_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      f5_v <= 1'b0;
    end else if (en) begin
      f5_v <= f4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f5_sum   <= f4_sum;
      f5_nstep <= (NSTEP_W'(f4_dwh) << A_W) + NSTEP_W'(f4_dwl);
      f5_nsig  <= (NSIG_W'(f4_hh) << (2 * A_W)) + (NSIG_W'(f4_hl) << (A_W + 1))
                  + NSIG_W'(f4_ll);
      f5_s     <= f4_s;
    end
  end

  logic           dv2_v;
  logic [W_W-1:0] q_sig;
  logic [W_W-1:0] q_step;
  side2_t         dv2_s;

  sdsf_div #(.N_W(NSIG_W), .D_W(SUM_W), .Q_W(W_W), .SIDE_W($bits(side2_t))) u_div_sig (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(f5_v), .in_num(f5_nsig), .in_den(f5_sum), .in_side(f5_s),
    .out_valid(dv2_v), .out_quo(q_sig), .out_side(dv2_s)
  );

  sdsf_div #(.N_W(NSTEP_W), .D_W(SUM_W), .Q_W(W_W), .SIDE_W(1)) u_div_step (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(f5_v), .in_num(f5_nstep), .in_den(f5_sum), .in_side(1'b0),
    .out_valid(), .out_quo(q_step), .out_side()
  );

  side3_t         sq_in;
  logic           sq_v;
  logic [A_W-1:0] root;
  side3_t         sq_s;

  assign sq_in.s    = dv2_s;
  assign sq_in.step = q_step[DB-1:0];

  sdsf_isqrt #(.V_W(W_W), .SIDE_W($bits(side3_t))) u_isqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(dv2_v), .in_val(q_sig), .in_side(sq_in),
    .out_valid(sq_v), .out_root(root), .out_side(sq_s)
  );

  // final select
  logic [DB-1:0] fuse_depth;
  logic [DB-1:0] fuse_sigma;
  logic [DB-1:0] res_depth;
  logic [DB-1:0] res_sigma;
  logic [31:0]   dep32;
  logic [31:0]   sig32;
  logic [OB_W-1:0] ob_in;
  logic [OB_W-1:0] ob_out;

  assign fuse_depth = sq_s.s.ge ? sq_s.s.da + sq_s.step : sq_s.s.da - sq_s.step;
  assign fuse_sigma = sat(64'(32'(root) << sq_s.s.sh));

  always_comb begin
    if (!sq_s.s.fv) begin
      // stereo only: pass the floored stereo sigma
      res_depth = sq_s.s.da;
      res_sigma = sq_s.s.sa;
    end else if (sq_s.s.sbz) begin
      res_depth = sq_s.s.db;
      res_sigma = '0;
    end else begin
      res_depth = fuse_depth;
      res_sigma = fuse_sigma;
    end
  end

  assign dep32 = 32'(res_depth);
  assign sig32 = 32'(res_sigma);
  assign ob_in = {sq_s.s.rep, sq_s.s.fv, sig32[sdsf_pkg::OUT_W-1:0],
                  dep32[sdsf_pkg::OUT_W-1:0]};

  sdsf_obuf #(.W(OB_W)) u_obuf (
    .clk(clk), .rst(rst),
    .push(sq_v && en), .push_data(ob_in), .full(ob_full),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(ob_out)
  );

  assign m_tdata = ob_out[2*sdsf_pkg::OUT_W-1:0];
  assign m_tuser = ob_out[OB_W-1:2*sdsf_pkg::OUT_W];

endmodule
`default_nettype wire

// ===== test/stereo_depth_sigma_fusion_core_test.sv =====
`default_nettype none
module stereo_depth_sigma_fusion_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned DMAX = 64'hFFFFFF;
  localparam int LATENCY = 200;
  localparam int WATCHDOG = 20000;
  localparam int QDEPTH = 1024;

  typedef struct packed {
    logic [23:0] depth;
    logic [23:0] sigma;
    logic        fused;
    logic        replaced;
  } pixel_result_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [sdsf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sdsf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  stereo_depth_sigma_fusion_core dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // 128-by-64 division by shift and subtract, quotient truncated to 64 bits
  function automatic longint unsigned mul_div(longint unsigned a, longint unsigned b,
                                              longint unsigned d);
    logic [127:0] p;
    logic [64:0] rem;
    longint unsigned q;
    p = 128'(a) * 128'(b);
    rem = 0;
    q = 0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[63:0], p[i]};
      q = q << 1;
      if (rem >= 65'(d)) begin
        rem = rem - 65'(d);
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned clamp(longint unsigned v);
    return v > DMAX ? DMAX : v;
  endfunction

  class fusion_scoreboard;
    longint unsigned fb, ssg, s2g, ceil_v, floor_v;
    pixel_result_t pending[QDEPTH];
    int head, tail;
    int errors;

    function new();
      fb = 64'(sdsf_pkg::FB_RST);
      ssg = 64'(sdsf_pkg::SSG_RST);
      s2g = 64'(sdsf_pkg::S2G_RST);
      ceil_v = 64'(sdsf_pkg::CEIL_RST);
      floor_v = 64'(sdsf_pkg::FLOOR_RST);
      head = 0;
      tail = 0;
      errors = 0;
    endfunction

    function int outstanding();
      return tail - head;
    endfunction

    function void write_reg(sdsf_pkg::cfg_idx_t idx, logic [23:0] v);
      case (idx)
        sdsf_pkg::CFG_FOCAL_BASELINE:    fb = 64'(v);
        sdsf_pkg::CFG_STEREO_SIGMA_GAIN: ssg = 64'(v[7:0]);
        sdsf_pkg::CFG_SECOND_SIGMA_GAIN: s2g = 64'(v[7:0]);
        sdsf_pkg::CFG_SIGMA_CEILING:     ceil_v = 64'(v);
        sdsf_pkg::CFG_SIGMA_FLOOR:       floor_v = 64'(v);
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [79:0] td, logic valid2);
      longint unsigned d, s, db, sraw, da, sa, sb, depth, sigma, m, a2, b2, wa, wb, sum;
      int sh;
      pixel_result_t r;
      d = 64'(td[15:0]); s = 64'(td[31:16]); db = 64'(td[55:32]); sraw = 64'(td[79:56]);
      r.fused = 1'b0; r.replaced = 1'b0;
      if (d == 0) begin
        da = DMAX; sa = ceil_v; r.replaced = 1'b1;
      end else begin
        da = clamp((fb << 10) / d);
        sa = (fb * s * ssg * 64) / (d * d);
      end
      if (sa < floor_v) sa = floor_v;
      sa = clamp(sa);
      depth = da; sigma = sa;
      if (valid2) begin
        r.fused = 1'b1;
        if (sraw == DMAX) begin
          sb = clamp(ceil_v); r.replaced = 1'b1;
        end else begin
          sb = clamp((sraw * s2g) >> 4);
        end
        if (sb == 0) begin
          depth = db; sigma = 0;
        end else begin
          m = sa > sb ? sa : sb;
          sh = 0;
          while ((m >> sh) >= (64'd1 << 31)) sh++;
          a2 = sa >> sh; b2 = sb >> sh;
          wa = b2 * b2; wb = a2 * a2; sum = wa + wb;
          if (db >= da) depth = da + mul_div(db - da, wb, sum);
          else depth = da - mul_div(da - db, wb, sum);
          sigma = clamp(int_sqrt(mul_div(wa, wb, sum)) << sh);
        end
      end
      r.depth = depth[23:0];
      r.sigma = sigma[23:0];
      pending[tail % QDEPTH] = r;
      tail++;
    endfunction

    function void check_pixel(logic [47:0] td, logic [1:0] tu);
      pixel_result_t e;
      if (outstanding() == 0) begin
        $error("unexpected result depth=%0d sigma=%0d", td[23:0], td[47:24]);
        errors++;
        return;
      end
      e = pending[head % QDEPTH];
      head++;
      if (td[23:0] !== e.depth) begin
        $error("out_depth expected %0d got %0d", e.depth, td[23:0]); errors++;
      end
      if (td[47:24] !== e.sigma) begin
        $error("out_sigma expected %0d got %0d", e.sigma, td[47:24]); errors++;
      end
      if (tu[0] !== e.fused) begin
        $error("was_fused expected %0d got %0d", e.fused, tu[0]); errors++;
      end
      if (tu[1] !== e.replaced) begin
        $error("sigma_replaced expected %0d got %0d", e.replaced, tu[1]); errors++;
      end
    endfunction
  endclass

  fusion_scoreboard sb = new();
  int idle_cycles = 0;
  bit timed_out = 0;

  // sample at rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_pixel(s_tdata, s_tuser);
      if (m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("** stereo_depth_sigma_fusion_core: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls per result
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 5) == 0) w = 0;
      if (w > 0) begin
        m_tready <= 0;
        repeat (w) @(negedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic write_cfg(sdsf_pkg::cfg_idx_t idx, logic [23:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [15:0] d, logic [15:0] s, logic v2, logic [23:0] db,
                            logic [23:0] s2, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 16) : 0;
    if (w > 0) begin
      s_tvalid <= 0;
      repeat (w) @(negedge clk);
    end
    s_tdata <= {s2, db, s, d};
    s_tuser <= v2;
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic random_pixel(bit gaps);
    logic [15:0] d, s;
    logic [23:0] db, s2;
    logic v2;
    case ($urandom_range(0, 5))
      0: d = 16'($urandom());
      1: d = 16'($urandom_range(0, 3));
      2: d = 16'(16'hFFFF - $urandom_range(0, 3));
      default: d = 16'($urandom_range(1, 4096));
    endcase
    s = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 256));
    v2 = 1'($urandom_range(0, 1));
    db = 24'($urandom());
    case ($urandom_range(0, 7))
      0: s2 = 24'hFFFFFF;
      1: s2 = 24'($urandom_range(0, 3));
      2: s2 = 24'($urandom());
      default: s2 = 24'($urandom_range(0, 1 << 18));
    endcase
    send_pixel(d, s, v2, db, s2, gaps);
  endtask

  initial begin
    logic [23:0] fbs[4], ceils[4], floors[4];
    logic [7:0] g1[4], g2[4];
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed corners at reset settings
    send_pixel(16'd0, 16'd0, 1'b0, 24'd0, 24'd0, 1'b0);
    send_pixel(16'd0, 16'hFFFF, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 1'b0, 24'd0, 24'd0, 1'b0);
    send_pixel(16'd1, 16'hFFFF, 1'b1, 24'hFFFFFF, 24'hFFFFFE, 1'b0);
    send_pixel(16'd64, 16'd64, 1'b1, 24'd100000, 24'd0, 1'b0);
    send_pixel(16'd64, 16'd64, 1'b1, 24'd0, 24'd65536, 1'b0);
    send_pixel(16'd640, 16'd32, 1'b1, 24'd500000, 24'd16384, 1'b0);
    send_pixel(16'd1, 16'd0, 1'b1, 24'd1, 24'd1, 1'b0);
    send_pixel(16'hAAAA, 16'h5555, 1'b1, 24'hAAAAAA, 24'h555555, 1'b0);
    send_pixel(16'h5555, 16'hAAAA, 1'b1, 24'h555555, 24'hAAAAAA, 1'b0);
    drain();

    fbs    = '{24'hFFFFFF, 24'd0, 24'd204800, 24'd4096};
    g1     = '{8'hFF, 8'd0, 8'd16, 8'd32};
    g2     = '{8'h00, 8'hFF, 8'd16, 8'd64};
    ceils  = '{24'hFFFFFF, 24'd0, 24'd6553600, 24'd65536};
    floors = '{24'd0, 24'hFFFFFF, 24'd655, 24'd0};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 4) begin
        write_cfg(sdsf_pkg::CFG_FOCAL_BASELINE, fbs[ph]);
        write_cfg(sdsf_pkg::CFG_STEREO_SIGMA_GAIN, 24'(g1[ph]));
        write_cfg(sdsf_pkg::CFG_SECOND_SIGMA_GAIN, 24'(g2[ph]));
        write_cfg(sdsf_pkg::CFG_SIGMA_CEILING, ceils[ph]);
        write_cfg(sdsf_pkg::CFG_SIGMA_FLOOR, floors[ph]);
      end else begin
        write_cfg(sdsf_pkg::CFG_FOCAL_BASELINE, 24'($urandom()));
        write_cfg(sdsf_pkg::CFG_STEREO_SIGMA_GAIN, 24'($urandom()));
        write_cfg(sdsf_pkg::CFG_SECOND_SIGMA_GAIN, 24'($urandom()));
        write_cfg(sdsf_pkg::CFG_SIGMA_CEILING, 24'($urandom()));
        write_cfg(sdsf_pkg::CFG_SIGMA_FLOOR, 24'($urandom_range(0, 4096)));
      end
      for (int i = 0; i < 380; i++) begin
        // stretches without gaps in the middle of each phase
        random_pixel(!(i >= 150 && i < 230));
        if (i == 100) begin
          s_tvalid <= 0;
          while (sb.outstanding() != 0) @(negedge clk);
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("** stereo_depth_sigma_fusion_core: PASSED **");
    else
      $display("** stereo_depth_sigma_fusion_core: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
